### rtl/assert_macros.svh
// Assertion macros shared by the packetizer RTL.
// Requires clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define H264FUA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("h264fua assertion failed");
// Check that a condition never holds outside reset.
`define H264FUA_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("h264fua forbidden condition seen");
`else
`define H264FUA_ASSERT(lbl, prop)
`define H264FUA_NEVER(lbl, cond)
`endif
`endif

### rtl/h264fua_pkg.sv
// Types and constants for the H.264 RTP FU-A packetizer.
// No dependencies; used by every module of the block.
`default_nettype none
package h264fua_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMESTAMP_STEP = 1'b1;
  localparam int CFG_DATA_W = 17;

  localparam logic [10:0] MAX_PAYLOAD_RST    = 11'd1400;
  localparam logic [16:0] TIMESTAMP_STEP_RST = 17'd3600;
  localparam logic [10:0] MIN_PAYLOAD        = 11'd2;

  // NAL header fields
  localparam logic [7:0] NRI_MASK  = 8'h60;
  localparam logic [7:0] TYPE_MASK = 8'h1F;
  localparam logic [7:0] FU_A_TYPE = 8'd28;
  localparam logic [7:0] S_BIT     = 8'h80;
  localparam logic [7:0] E_BIT     = 8'h40;
  localparam logic [4:0] SPS_TYPE  = 5'd7;
  localparam logic [4:0] PPS_TYPE  = 5'd8;

  // Command queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One classified input byte: optional FU-A indicator and header, then data
  typedef struct packed {
    logic        has_fu;
    logic [7:0]  ind;
    logic [7:0]  fuh;
    logic [7:0]  data;
    logic        first;
    logic        last;
    logic [15:0] seq;
    logic [31:0] ts;
  } cmd_t;

endpackage
`default_nettype wire

### rtl/h264_rtp_fu_a_packetizer.sv
// Top level of the H.264 RTP FU-A packetizer.
// Depends on h264fua_pkg, h264fua_front, h264fua_queue and h264fua_back.
`default_nettype none
// The block takes one NAL byte per cycle while the command queue is not full
// and emits RTP payload bytes, one per cycle while out_tready holds, each
// tagged with packet start/end, sequence number and timestamp. Units no
// longer than max_payload pass through whole; longer units drop the header
// byte and go out as FU-A fragments, each opened by an indicator and an FU
// header byte. The first byte of a fragment makes three output bytes, so the
// output register (one byte per cycle while out_tready holds) sets the
// sustained rate. A four-entry command queue lets input continue while the
// output stalls. Each byte passes through the queue and then the output
// register. The header byte of a fragmented unit makes no output.
module h264_rtp_fu_a_packetizer #(
  parameter int LENGTH_BITS = 20
) (
  input  wire         clk,
  input  wire         rst_n,
  // configuration write port
  input  wire         cfg_wr_en,
  input  wire  [0:0]  cfg_index,
  input  wire  [16:0] cfg_wr_data,
  // input stream
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [31:0] in_tdata,   // [7:0] nal_byte, [27:8] nal_length, zero fill
  input  wire         in_tlast,   // nal_last
  // output stream
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [55:0] out_tdata,  // [7:0] out_byte, [23:8] seq_number,
                                  // [55:24] rtp_timestamp
  output logic        out_tlast,  // packet_last
  output logic [0:0]  out_tuser   // [0] packet_first
);
  import h264fua_pkg::*;

  logic        q_full, q_push, q_pop, q_valid;
  cmd_t        q_in_cmd, q_head_cmd;
  logic [7:0]  out_byte;
  logic        packet_first;
  logic [15:0] seq_number;
  logic [31:0] rtp_timestamp;

  h264fua_front #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .nal_byte    (in_tdata[7:0]),
    .nal_length  (in_tdata[27:8]),
    .nal_last    (in_tlast),
    .q_full      (q_full),
    .push        (q_push),
    .push_cmd    (q_in_cmd)
  );

  h264fua_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_in_cmd),
    .full       (q_full),
    .head_valid (q_valid),
    .head_cmd   (q_head_cmd),
    .pop        (q_pop)
  );

  h264fua_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_valid    (q_valid),
    .head_cmd      (q_head_cmd),
    .pop           (q_pop),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_byte      (out_byte),
    .packet_first  (packet_first),
    .packet_last   (out_tlast),
    .seq_number    (seq_number),
    .rtp_timestamp (rtp_timestamp)
  );

  assign out_tdata = {rtp_timestamp, seq_number, out_byte};
  assign out_tuser = packet_first;

endmodule
`default_nettype wire

### rtl/h264fua_front.sv
// Front end: accepts NAL bytes, tracks unit and fragment state, builds commands.
// Depends on h264fua_pkg; feeds h264fua_queue.
`default_nettype none
module h264fua_front #(
  parameter int LENGTH_BITS = 20
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 cfg_wr_en,
  input  wire  [h264fua_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [h264fua_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wire  [7:0]                          nal_byte,
  input  wire  [19:0]                         nal_length,
  input  wire                                 nal_last,
  input  wire                                 q_full,
  output logic                                push,
  output h264fua_pkg::cmd_t                   push_cmd
);
  import h264fua_pkg::*;

  localparam int CW = ((LENGTH_BITS > 20) ? LENGTH_BITS : 20) + 2;
  localparam logic [LENGTH_BITS-1:0] CNT_MAX = {LENGTH_BITS{1'b1}};

  logic [10:0]            max_payload_r;
  logic [16:0]            timestamp_step_r;
  logic [15:0]            seq_r, seq_nxt;
  logic [31:0]            ts_r, ts_nxt;
  logic [7:0]             hdr_r, hdr_nxt;
  logic [LENGTH_BITS-1:0] done_r, done_nxt;
  logic [10:0]            fill_r, fill_nxt;
  logic                   mode_r, mode_nxt;

  logic [10:0]   mp;
  logic [CW-1:0] done_w, len_w, mp_w, fill_w;
  logic          unit_end, emit, pkt_done, s_flag, e_flag, in_first, frag_end;
  logic [4:0]    nal_type;
  logic          in_fire;
  cmd_t          cmd;

  assign in_ready = !q_full;
  assign in_fire  = in_valid && in_ready;
  assign push     = in_fire && emit;
  assign push_cmd = cmd;

  // Classify the byte and compute the next unit state
  always_comb begin
    mp       = (max_payload_r < MIN_PAYLOAD) ? MIN_PAYLOAD : max_payload_r;
    done_w   = CW'(done_r);
    len_w    = CW'(nal_length);
    mp_w     = CW'(mp);
    fill_w   = CW'(fill_r);
    unit_end = nal_last || (done_w + CW'(1) >= len_w);
    emit     = 1'b0;
    pkt_done = 1'b0;
    s_flag   = 1'b0;
    e_flag   = 1'b0;
    in_first = 1'b0;
    frag_end = 1'b0;
    hdr_nxt  = hdr_r;
    mode_nxt = mode_r;
    fill_nxt = fill_r;
    cmd      = '0;
    cmd.data = nal_byte;
    cmd.seq  = seq_r;
    cmd.ts   = ts_r;

    if (done_r == '0) begin
      hdr_nxt  = nal_byte;
      mode_nxt = (len_w > mp_w) && !unit_end;
      if (!mode_nxt) begin
        emit      = 1'b1;
        cmd.first = 1'b1;
        cmd.last  = unit_end;
        pkt_done  = unit_end;
      end
    end else if (!mode_r) begin
      emit     = 1'b1;
      cmd.last = unit_end;
      pkt_done = unit_end;
    end else begin
      s_flag   = (done_r == LENGTH_BITS'(1));
      e_flag   = !s_flag && (len_w <= done_w + mp_w);
      in_first = (done_w == fill_w + CW'(1));
      if (fill_r == '0) begin
        cmd.has_fu = 1'b1;
        cmd.ind    = (hdr_r & NRI_MASK) | FU_A_TYPE;
        cmd.fuh    = (hdr_r & TYPE_MASK) | (s_flag ? S_BIT : 8'h00)
                   | (e_flag ? E_BIT : 8'h00);
      end
      frag_end = unit_end || (fill_w + CW'(1) >= mp_w)
               || (in_first && (len_w != '0) && (len_w <= mp_w + CW'(1))
                   && (done_w + CW'(2) >= len_w));
      emit     = 1'b1;
      cmd.last = frag_end;
      pkt_done = frag_end;
      fill_nxt = frag_end ? 11'd0 : fill_r + 11'd1;
    end

    seq_nxt  = pkt_done ? seq_r + 16'd1 : seq_r;
    nal_type = hdr_nxt[4:0];
    ts_nxt   = ts_r;
    if (unit_end) begin
      if (nal_type != SPS_TYPE && nal_type != PPS_TYPE) begin
        ts_nxt = ts_r + 32'(timestamp_step_r);
      end
      done_nxt = '0;
      fill_nxt = '0;
      mode_nxt = 1'b0;
    end else begin
      done_nxt = (done_r == CNT_MAX) ? done_r : done_r + LENGTH_BITS'(1);
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r    <= MAX_PAYLOAD_RST;
      timestamp_step_r <= TIMESTAMP_STEP_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_MAX_PAYLOAD:    max_payload_r    <= cfg_wr_data[10:0];
        REG_TIMESTAMP_STEP: timestamp_step_r <= cfg_wr_data[16:0];
        default: ;
      endcase
    end
  end

  // Unit state: advance on each accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r  <= '0;
      ts_r   <= '0;
      hdr_r  <= '0;
      done_r <= '0;
      fill_r <= '0;
      mode_r <= 1'b0;
    end else if (in_fire) begin
      seq_r  <= seq_nxt;
      ts_r   <= ts_nxt;
      hdr_r  <= hdr_nxt;
      done_r <= done_nxt;
      fill_r <= fill_nxt;
      mode_r <= mode_nxt;
    end
  end

`include "assert_macros.svh"
  `H264FUA_ASSERT(a_fill_idle, !mode_r |-> fill_r == '0)
  `H264FUA_ASSERT(a_mode_needs_header, done_r == '0 |-> !mode_r)

endmodule
`default_nettype wire

### rtl/h264fua_queue.sv
// Short command queue between the front and back ends.
// Depends on h264fua_pkg for cmd_t and the queue depth.
`default_nettype none
module h264fua_queue (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                push,
  input  h264fua_pkg::cmd_t  push_cmd,
  output logic               full,
  output logic               head_valid,
  output h264fua_pkg::cmd_t  head_cmd,
  input  wire                pop
);
  import h264fua_pkg::*;

  cmd_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

`include "assert_macros.svh"
  `H264FUA_NEVER(a_push_full, push && full)
  `H264FUA_NEVER(a_pop_empty, pop && !head_valid)

endmodule
`default_nettype wire

### rtl/h264fua_back.sv
// Back end: expands each command into one or three payload bytes.
// Depends on h264fua_pkg; reads from h264fua_queue, drives the output register.
`default_nettype none
module h264fua_back (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                head_valid,
  input  h264fua_pkg::cmd_t  head_cmd,
  output logic               pop,
  output logic               out_valid,
  input  wire                out_ready,
  output logic [7:0]         out_byte,
  output logic               packet_first,
  output logic               packet_last,
  output logic [15:0]        seq_number,
  output logic [31:0]        rtp_timestamp
);
  import h264fua_pkg::*;

  typedef enum logic [1:0] {PH_IND, PH_HDR, PH_DATA} phase_t;

  phase_t      phase_r, phase_nxt;
  logic        valid_r;
  logic [7:0]  byte_r;
  logic        first_r, last_r;
  logic [15:0] seq_r;
  logic [31:0] ts_r;

  logic        load, entry_done;
  logic [7:0]  sel_byte;
  logic        sel_first, sel_last;

  assign load = head_valid && (!valid_r || out_ready);
  assign pop  = load && entry_done;

  // Pick the byte for the current phase of the head command
  always_comb begin
    sel_byte   = head_cmd.data;
    sel_first  = head_cmd.first;
    sel_last   = head_cmd.last;
    entry_done = 1'b1;
    phase_nxt  = PH_IND;
    if (head_cmd.has_fu) begin
      case (phase_r)
        PH_IND: begin
          sel_byte   = head_cmd.ind;
          sel_first  = 1'b1;
          sel_last   = 1'b0;
          entry_done = 1'b0;
          phase_nxt  = PH_HDR;
        end
        PH_HDR: begin
          sel_byte   = head_cmd.fuh;
          sel_first  = 1'b0;
          sel_last   = 1'b0;
          entry_done = 1'b0;
          phase_nxt  = PH_DATA;
        end
        PH_DATA: begin
          sel_first = 1'b0;
        end
        default: begin
          sel_first = 1'b0;
        end
      endcase
    end
  end

  // Phase and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IND;
      valid_r <= 1'b0;
    end else begin
      if (load) begin
        phase_r <= phase_nxt;
        valid_r <= 1'b1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r  <= sel_byte;
      first_r <= sel_first;
      last_r  <= sel_last;
      seq_r   <= head_cmd.seq;
      ts_r    <= head_cmd.ts;
    end
  end

  assign out_valid     = valid_r;
  assign out_byte      = byte_r;
  assign packet_first  = first_r;
  assign packet_last   = last_r;
  assign seq_number    = seq_r;
  assign rtp_timestamp = ts_r;

endmodule
`default_nettype wire
